@@ rtl/barometer_compensation_defines.svh @@
// Assertion macros for the barometer compensation block.
`ifndef BAROMETER_COMPENSATION_DEFINES_SVH
`define BAROMETER_COMPENSATION_DEFINES_SVH

// Check that prop holds in the same cycle as cond.
`define BC_ASSERT_IMPLY(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("barometer_compensation: same-cycle check failed");

// Check that prop holds in the cycle after cond.
`define BC_ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("barometer_compensation: next-cycle check failed");

`endif

@@ rtl/baro_pkg.sv @@
// Types, constants and helper functions shared by the barometer compensation block.
`timescale 1ns / 1ps
`default_nettype none

package baro_pkg;

   typedef struct packed {
      logic        operation;
      logic [23:0] raw_reading;
   } baro_req_type;

   typedef struct packed {
      logic               result_kind;
      logic signed [15:0] temperature_tenths;
      logic [19:0]        pressure_pa;
      logic               divide_error;
   } baro_rsp_type;

   typedef struct packed {
      logic start;
      logic is_div;
   } baro_mdu_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } baro_mdu_stat_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_T_MUL,
      ST_T_DIV,
      ST_T_OUT,
      ST_P_SQ,
      ST_P_X1,
      ST_P_X2,
      ST_P_B3A,
      ST_P_B3B,
      ST_P_X3,
      ST_P_X4,
      ST_P_X5,
      ST_P_B4,
      ST_P_B7,
      ST_P_DIV,
      ST_P_PSQ,
      ST_P_K1,
      ST_P_K2,
      ST_P_OUT
   } baro_state_type;

   // Register indexes (byte address / 4).
   localparam logic [2:0] REG_AC1_AC2 = 3'd0;
   localparam logic [2:0] REG_AC3_AC4 = 3'd1;
   localparam logic [2:0] REG_AC5_AC6 = 3'd2;
   localparam logic [2:0] REG_B1_B2   = 3'd3;
   localparam logic [2:0] REG_MC_MD   = 3'd4;
   localparam logic [2:0] REG_OSS     = 3'd5;

   localparam logic [1:0] OSS_RESET = 2'd3;

   localparam logic signed [31:0] B6_OFFSET  = 32'sd4000;
   localparam logic signed [63:0] B4_BIAS    = 64'sd32768;
   localparam logic [63:0]        B7_BASE    = 64'd50000;
   localparam logic signed [63:0] K_SQUARE   = 64'sd3038;
   localparam logic signed [63:0] K_LINEAR   = -64'sd7357;
   localparam logic signed [63:0] K_OFFSET   = 64'sd3791;
   localparam logic signed [63:0] T_ROUND    = 64'sd8;
   localparam logic signed [63:0] B3_ROUND   = 64'sd2;
   localparam logic signed [63:0] X3_ROUND   = 64'sd2;
   localparam logic signed [63:0] TEMP_MAX   = 64'sd32767;
   localparam logic signed [63:0] TEMP_MIN   = -64'sd32768;
   localparam logic signed [63:0] PRES_MAX   = 64'sd1048575;

   localparam int unsigned MUL_DIGIT = 4;
   localparam int unsigned DIV_STEPS = 32;

   // Signed divide by 2**k, truncating toward zero.
   function automatic logic signed [63:0] trunc_shr(input logic signed [63:0] v,
                                                    input logic [5:0] k);
      logic signed [63:0] bias;
      bias = v[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
      return (v + bias) >>> k;
   endfunction

   function automatic logic [63:0] abs64(input logic signed [63:0] v);
      return v[63] ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic signed [63:0] sx16(input logic [15:0] v);
      return 64'(signed'(v));
   endfunction

   function automatic logic signed [63:0] zx16(input logic [15:0] v);
      return $signed({48'd0, v});
   endfunction

endpackage

`default_nettype wire

@@ rtl/baro_mdu.sv @@
// Shared multiply/divide unit: radix-16 shift-add multiplier and restoring divider.
`timescale 1ns / 1ps
`default_nettype none

module baro_mdu (
   input  logic                          clock,
   input  logic                          reset,
   input  baro_pkg::baro_mdu_cmd_type    cmd,
   input  logic signed [63:0]            op_a,
   input  logic signed [63:0]            op_b,
   output baro_pkg::baro_mdu_stat_type   stat,
   output logic signed [63:0]            result
);
   import baro_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        div_ff, div_in;
   logic        neg_ff, neg_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] ma_ff, ma_in;
   logic [63:0] mb_ff, mb_in;
   logic [4:0]  cnt_ff, cnt_in;

   logic [63:0] mag_a, mag_b, pp, prod;
   logic [32:0] rem_sh, diff;
   logic        fits;

   always_comb begin
      mag_a = abs64(op_a);
      mag_b = abs64(op_b);
      busy_in = busy_ff;
      done_in = 1'b0;
      div_in  = div_ff;
      neg_in  = neg_ff;
      acc_in  = acc_ff;
      ma_in   = ma_ff;
      mb_in   = mb_ff;
      cnt_in  = cnt_ff;
      pp      = '0;
      rem_sh  = {acc_ff[31:0], ma_ff[31]};
      diff    = rem_sh - {1'b0, mb_ff[31:0]};
      fits    = rem_sh >= {1'b0, mb_ff[31:0]};
      if (cmd.start) begin
         busy_in = 1'b1;
         div_in  = cmd.is_div;
         neg_in  = op_a[63] ^ op_b[63];
         acc_in  = '0;
         cnt_in  = '0;
         if (cmd.is_div) begin
            ma_in = {32'd0, mag_a[31:0]};
            mb_in = {32'd0, mag_b[31:0]};
         end else begin
            ma_in = mag_a;
            mb_in = mag_b;
         end
      end else if (busy_ff) begin
         if (div_ff) begin
            // one quotient bit per cycle
            acc_in = {32'd0, fits ? diff[31:0] : rem_sh[31:0]};
            ma_in  = {32'd0, ma_ff[30:0], fits};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(DIV_STEPS - 1)) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end else begin
            // one multiplier digit per cycle; stop once the rest is zero
            for (int i = 0; i < MUL_DIGIT; i++) begin
               if (mb_ff[i]) pp = pp + (ma_ff << i);
            end
            acc_in = acc_ff + pp;
            ma_in  = ma_ff << MUL_DIGIT;
            mb_in  = mb_ff >> MUL_DIGIT;
            if ((mb_ff >> MUL_DIGIT) == 64'd0) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      div_ff <= div_in;
      neg_ff <= neg_in;
      acc_ff <= acc_in;
      ma_ff  <= ma_in;
      mb_ff  <= mb_in;
      cnt_ff <= cnt_in;
   end

   always_comb begin
      prod   = div_ff ? {32'd0, ma_ff[31:0]} : acc_ff;
      result = neg_ff ? $signed(64'(-prod)) : $signed(prod);
      stat.busy = busy_ff;
      stat.done = done_ff;
   end

endmodule

`default_nettype wire

@@ rtl/barometer_compensation.sv @@
// Top level of the barometer compensation block: registers, sequencer and output stage.
`timescale 1ns / 1ps
`default_nettype none
`include "barometer_compensation_defines.svh"

// Usage:
// - req channel: one transfer carries an operation (0 temperature, 1 pressure) and the
//   raw sensor bytes. req_ready is high only while the sequencer is idle.
// - rsp channel: exactly one result transfer per request, in request order.
// - csr port: APB-style, register i at byte address 4*i; pready is always high.
//   Write the calibration words and oversampling only while no request is in flight.
// - A temperature request runs a short multiply through the shared unit, a divide,
//   then the output stage. It also updates the stored B5 used by later pressure
//   requests.
// - A pressure request runs ten multiplies and one divide, all on the single shared
//   multiply/divide unit. Multiply time follows the number of significant hex digits
//   of the second operand's magnitude; a zero B4 ends it early.
// - The result waits in an output register; if the next result is ready while the receiver
//   still stalls, the sequencer holds in its final state and takes no new request.
// - A zero divisor sets divide_error and zeroes the value fields; B5 is kept.
// - Synchronous reset clears the calibration words to zero, oversampling to 3, the
//   stored B5 to zero, and drops any request in flight.

module barometer_compensation (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  baro_pkg::baro_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output baro_pkg::baro_rsp_type rsp_data,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [4:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);
   import baro_pkg::*;

   // configuration registers
   logic [31:0] cal_ac1_ac2_ff, cal_ac1_ac2_in;
   logic [31:0] cal_ac3_ac4_ff, cal_ac3_ac4_in;
   logic [31:0] cal_ac5_ac6_ff, cal_ac5_ac6_in;
   logic [31:0] cal_b1_b2_ff, cal_b1_b2_in;
   logic [31:0] cal_mc_md_ff, cal_mc_md_in;
   logic [1:0]  oss_ff, oss_in;

   // sequencer and work registers
   baro_state_type     state_ff, state_in;
   logic               issued_ff, issued_in;
   logic               err_ff, err_in;
   logic [23:0]        raw_ff, raw_in;
   logic signed [31:0] temp_b5_ff, temp_b5_in;
   logic signed [31:0] b6_ff, b6_in;
   logic signed [63:0] x1_ff, x1_in;
   logic signed [63:0] x2_ff, x2_in;
   logic signed [63:0] sq_ff, sq_in;
   logic signed [63:0] b3_ff, b3_in;
   logic [16:0]        b4_ff, b4_in;
   logic [31:0]        b7_ff, b7_in;
   logic signed [31:0] p_ff, p_in;

   // output stage
   logic         rsp_valid_ff, rsp_valid_in;
   baro_rsp_type rsp_data_ff, rsp_data_in;

   // shared unit
   baro_mdu_cmd_type   mdu_cmd;
   baro_mdu_stat_type  mdu_stat;
   logic signed [63:0] mdu_a, mdu_b, mdu_res;

   logic               csr_wr;
   logic               out_free;
   logic signed [63:0] b6s, den, tval, pval, pd;
   logic [31:0]        up_w, q_w;

   baro_mdu u_mdu (
      .clock  (clock),
      .reset  (reset),
      .cmd    (mdu_cmd),
      .op_a   (mdu_a),
      .op_b   (mdu_b),
      .stat   (mdu_stat),
      .result (mdu_res)
   );

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cal_ac1_ac2_in = cal_ac1_ac2_ff;
      cal_ac3_ac4_in = cal_ac3_ac4_ff;
      cal_ac5_ac6_in = cal_ac5_ac6_ff;
      cal_b1_b2_in   = cal_b1_b2_ff;
      cal_mc_md_in   = cal_mc_md_ff;
      oss_in         = oss_ff;
      if (csr_wr) begin
         case (csr_paddr[4:2])
            REG_AC1_AC2: cal_ac1_ac2_in = csr_pwdata;
            REG_AC3_AC4: cal_ac3_ac4_in = csr_pwdata;
            REG_AC5_AC6: cal_ac5_ac6_in = csr_pwdata;
            REG_B1_B2:   cal_b1_b2_in   = csr_pwdata;
            REG_MC_MD:   cal_mc_md_in   = csr_pwdata;
            REG_OSS:     oss_in         = csr_pwdata[1:0];
            default:     ;  // drop writes beyond the register list
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         REG_AC1_AC2: csr_prdata = cal_ac1_ac2_ff;
         REG_AC3_AC4: csr_prdata = cal_ac3_ac4_ff;
         REG_AC5_AC6: csr_prdata = cal_ac5_ac6_ff;
         REG_B1_B2:   csr_prdata = cal_b1_b2_ff;
         REG_MC_MD:   csr_prdata = cal_mc_md_ff;
         REG_OSS:     csr_prdata = {30'd0, oss_ff};
         default:     csr_prdata = '0;
      endcase
   end

   // ---------------- sequencer ----------------
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      issued_in    = issued_ff;
      err_in       = err_ff;
      raw_in       = raw_ff;
      temp_b5_in   = temp_b5_ff;
      b6_in        = b6_ff;
      x1_in        = x1_ff;
      x2_in        = x2_ff;
      sq_in        = sq_ff;
      b3_in        = b3_ff;
      b4_in        = b4_ff;
      b7_in        = b7_ff;
      p_in         = p_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mdu_cmd      = '0;
      mdu_a        = '0;
      mdu_b        = '0;

      out_free = !rsp_valid_ff || rsp_ready;
      b6s      = 64'(b6_ff);
      den      = x1_ff + sx16(cal_mc_md_ff[15:0]);
      up_w     = 32'({8'd0, raw_ff} >> (4'd8 - {2'b00, oss_ff}));
      q_w      = b7_ff[31] ? {mdu_res[30:0], 1'b0} : mdu_res[31:0];
      pd       = trunc_shr(64'(p_ff), 6'd8);
      tval     = trunc_shr(x2_ff + T_ROUND, 6'd4);
      pval     = 64'(p_ff) + trunc_shr(x1_ff + x2_ff + K_OFFSET, 6'd4);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               raw_in    = req_data.raw_reading;
               err_in    = 1'b0;
               issued_in = 1'b0;
               b6_in     = temp_b5_ff - B6_OFFSET;
               state_in  = req_data.operation ? ST_P_SQ : ST_T_MUL;
            end
         end

         // X1 = floor((UT - AC6) * AC5 / 2**15)
         ST_T_MUL: begin
            if (!issued_ff) begin
               mdu_cmd.start = 1'b1;
               mdu_a     = zx16(raw_ff[15:0]) - zx16(cal_ac5_ac6_ff[15:0]);
               mdu_b     = zx16(cal_ac5_ac6_ff[31:16]);
               issued_in = 1'b1;
            end else if (mdu_stat.done) begin
               x1_in     = mdu_res >>> 15;
               issued_in = 1'b0;
               state_in  = ST_T_DIV;
            end
         end

         // B5 = X1 + MC * 2048 / (X1 + MD)
         ST_T_DIV: begin
            if (!issued_ff) begin
               if (den == 64'sd0) begin
                  err_in   = 1'b1;
                  state_in = ST_T_OUT;
               end else begin
                  mdu_cmd.start  = 1'b1;
                  mdu_cmd.is_div = 1'b1;
                  mdu_a     = sx16(cal_mc_md_ff[31:16]) <<< 11;
                  mdu_b     = den;
                  issued_in = 1'b1;
               end
            end else if (mdu_stat.done) begin
               x2_in     = x1_ff + mdu_res;
               issued_in = 1'b0;
               state_in  = ST_T_OUT;
            end
         end

         ST_T_OUT: begin
            if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.result_kind     = 1'b0;
               rsp_data_in.divide_error    = err_ff;
               rsp_data_in.pressure_pa     = '0;
               if (err_ff) begin
                  rsp_data_in.temperature_tenths = '0;
               end else begin
                  temp_b5_in = x2_ff[31:0];
                  if (tval > TEMP_MAX)
                     rsp_data_in.temperature_tenths = TEMP_MAX[15:0];
                  else if (tval < TEMP_MIN)
                     rsp_data_in.temperature_tenths = TEMP_MIN[15:0];
                  else
                     rsp_data_in.temperature_tenths = tval[15:0];
               end
               state_in = ST_IDLE;
            end
         end

         // B6 squared / 4096
         ST_P_SQ: begin
            if (!issued_ff) begin
               mdu_cmd.start = 1'b1;
               mdu_a = b6s;
               mdu_b = b6s;
               issued_in = 1'b1;
            end else if (mdu_stat.done) begin
               sq_in     = mdu_res >>> 12;
               issued_in = 1'b0;
               state_in  = ST_P_X1;
            end
         end

         ST_P_X1: begin
            if (!issued_ff) begin
               mdu_cmd.start = 1'b1;
               mdu_a = sq_ff;
               mdu_b = sx16(cal_b1_b2_ff[15:0]);
               issued_in = 1'b1;
            end else if (mdu_stat.done) begin
               x1_in     = trunc_shr(mdu_res, 6'd11);
               issued_in = 1'b0;
               state_in  = ST_P_X2;
            end
         end

         ST_P_X2: begin
            if (!issued_ff) begin
               mdu_cmd.start = 1'b1;
               mdu_a = b6s;
               mdu_b = sx16(cal_ac1_ac2_ff[15:0]);
               issued_in = 1'b1;
            end else if (mdu_stat.done) begin
               x2_in     = trunc_shr(mdu_res, 6'd11);
               issued_in = 1'b0;
               state_in  = ST_P_B3A;
            end
         end

         // B3 = ((AC1 * 4 + X3) << oss + 2) / 4
         ST_P_B3A: begin
            b3_in    = ((sx16(cal_ac1_ac2_ff[31:16]) <<< 2) + x1_ff + x2_ff) <<< oss_ff;
            state_in = ST_P_B3B;
         end

         ST_P_B3B: begin
            b3_in    = trunc_shr(b3_ff + B3_ROUND, 6'd2);
            state_in = ST_P_X3;
         end

         ST_P_X3: begin
            if (!issued_ff) begin
               mdu_cmd.start = 1'b1;
               mdu_a = b6s;
               mdu_b = sx16(cal_ac3_ac4_ff[31:16]);
               issued_in = 1'b1;
            end else if (mdu_stat.done) begin
               x1_in     = trunc_shr(mdu_res, 6'd13);
               issued_in = 1'b0;
               state_in  = ST_P_X4;
            end
         end

         ST_P_X4: begin
            if (!issued_ff) begin
               mdu_cmd.start = 1'b1;
               mdu_a = sq_ff;
               mdu_b = sx16(cal_b1_b2_ff[31:16]);
               issued_in = 1'b1;
            end else if (mdu_stat.done) begin
               x2_in     = trunc_shr(mdu_res, 6'd16);
               issued_in = 1'b0;
               state_in  = ST_P_X5;
            end
         end

         ST_P_X5: begin
            x1_in    = trunc_shr(x1_ff + x2_ff + X3_ROUND, 6'd2);
            state_in = ST_P_B4;
         end

         // B4 = AC4 * (X3 + 32768) / 32768, modulo 2**32
         ST_P_B4: begin
            if (!issued_ff) begin
               mdu_cmd.start = 1'b1;
               mdu_a = $signed({32'd0, 32'(x1_ff + B4_BIAS)});
               mdu_b = zx16(cal_ac3_ac4_ff[15:0]);
               issued_in = 1'b1;
            end else if (mdu_stat.done) begin
               b4_in     = mdu_res[31:15];
               issued_in = 1'b0;
               state_in  = ST_P_B7;
            end
         end

         // B7 = (UP - B3) * (50000 >> oss), modulo 2**32
         ST_P_B7: begin
            if (!issued_ff) begin
               if (b4_ff == '0) begin
                  err_in   = 1'b1;
                  state_in = ST_P_OUT;
               end else begin
                  mdu_cmd.start = 1'b1;
                  mdu_a = $signed({32'd0, up_w - b3_ff[31:0]});
                  mdu_b = $signed(B7_BASE >> oss_ff);
                  issued_in = 1'b1;
               end
            end else if (mdu_stat.done) begin
               b7_in     = mdu_res[31:0];
               issued_in = 1'b0;
               state_in  = ST_P_DIV;
            end
         end

         ST_P_DIV: begin
            if (!issued_ff) begin
               mdu_cmd.start  = 1'b1;
               mdu_cmd.is_div = 1'b1;
               mdu_a = $signed({32'd0, b7_ff[31] ? b7_ff : {b7_ff[30:0], 1'b0}});
               mdu_b = $signed({47'd0, b4_ff});
               issued_in = 1'b1;
            end else if (mdu_stat.done) begin
               p_in      = $signed(q_w);
               issued_in = 1'b0;
               state_in  = ST_P_PSQ;
            end
         end

         ST_P_PSQ: begin
            if (!issued_ff) begin
               mdu_cmd.start = 1'b1;
               mdu_a = pd;
               mdu_b = pd;
               issued_in = 1'b1;
            end else if (mdu_stat.done) begin
               x1_in     = mdu_res;
               issued_in = 1'b0;
               state_in  = ST_P_K1;
            end
         end

         ST_P_K1: begin
            if (!issued_ff) begin
               mdu_cmd.start = 1'b1;
               mdu_a = x1_ff;
               mdu_b = K_SQUARE;
               issued_in = 1'b1;
            end else if (mdu_stat.done) begin
               x1_in     = trunc_shr(mdu_res, 6'd16);
               issued_in = 1'b0;
               state_in  = ST_P_K2;
            end
         end

         ST_P_K2: begin
            if (!issued_ff) begin
               mdu_cmd.start = 1'b1;
               mdu_a = 64'(p_ff);
               mdu_b = K_LINEAR;
               issued_in = 1'b1;
            end else if (mdu_stat.done) begin
               x2_in     = trunc_shr(mdu_res, 6'd16);
               issued_in = 1'b0;
               state_in  = ST_P_OUT;
            end
         end

         ST_P_OUT: begin
            if (out_free) begin
               rsp_valid_in                   = 1'b1;
               rsp_data_in.result_kind        = 1'b1;
               rsp_data_in.divide_error       = err_ff;
               rsp_data_in.temperature_tenths = '0;
               if (err_ff || pval < 64'sd0)
                  rsp_data_in.pressure_pa = '0;
               else if (pval > PRES_MAX)
                  rsp_data_in.pressure_pa = PRES_MAX[19:0];
               else
                  rsp_data_in.pressure_pa = pval[19:0];
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ac1_ac2_ff <= '0;
         cal_ac3_ac4_ff <= '0;
         cal_ac5_ac6_ff <= '0;
         cal_b1_b2_ff   <= '0;
         cal_mc_md_ff   <= '0;
         oss_ff         <= OSS_RESET;
         temp_b5_ff     <= '0;
         state_ff       <= ST_IDLE;
         issued_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         cal_ac1_ac2_ff <= cal_ac1_ac2_in;
         cal_ac3_ac4_ff <= cal_ac3_ac4_in;
         cal_ac5_ac6_ff <= cal_ac5_ac6_in;
         cal_b1_b2_ff   <= cal_b1_b2_in;
         cal_mc_md_ff   <= cal_mc_md_in;
         oss_ff         <= oss_in;
         temp_b5_ff     <= temp_b5_in;
         state_ff       <= state_in;
         issued_ff      <= issued_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      err_ff      <= err_in;
      raw_ff      <= raw_in;
      b6_ff       <= b6_in;
      x1_ff       <= x1_in;
      x2_ff       <= x2_in;
      sq_ff       <= sq_in;
      b3_ff       <= b3_in;
      b4_ff       <= b4_in;
      b7_ff       <= b7_in;
      p_ff        <= p_in;
      rsp_data_ff <= rsp_data_in;
   end

   // ---------------- checks ----------------
   `BC_ASSERT_NEXT(a_accept_leaves_idle, req_valid && req_ready, state_ff != ST_IDLE)
   `BC_ASSERT_IMPLY(a_done_when_issued, mdu_stat.done, issued_ff)
   `BC_ASSERT_IMPLY(a_error_zeroes, rsp_valid_ff && rsp_data_ff.divide_error, rsp_data_ff.temperature_tenths == 16'sd0 && rsp_data_ff.pressure_pa == 20'd0)
   `BC_ASSERT_IMPLY(a_temp_no_pressure, rsp_valid_ff && !rsp_data_ff.result_kind, rsp_data_ff.pressure_pa == 20'd0)

endmodule

`default_nettype wire

@@ tb/sv/tb_barometer_compensation.sv @@
// Self-checking testbench for the barometer compensation block.
`timescale 1ns / 1ps

module tb_barometer_compensation;
   import baro_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   baro_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   baro_rsp_type rsp_data;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [4:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   // Shadow copies of the calibration registers and the stored B5.
   logic [31:0]        shadow_ac12, shadow_ac34, shadow_ac56, shadow_b12, shadow_mcmd;
   logic [1:0]         shadow_oss;
   logic signed [31:0] shadow_b5;

   baro_rsp_type expected_results[$];
   int           error_count = 0;
   bit           rsp_stall_enable = 1'b1;
   bit           req_gap_enable = 1'b1;

   barometer_compensation u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #6 clock = ~clock;

   // Signed division truncating toward zero, on 64-bit values.
   function automatic longint tdiv(input longint num, input longint den);
      longint q;
      q = num / den;
      return q;
   endfunction

   // Compute the compensated result of one reading and advance the stored B5.
   function automatic baro_rsp_type compensate(input baro_req_type item);
      baro_rsp_type       r;
      longint             ut, x1, x2, x3, den, b5, t, b6, sq, b3, p;
      logic [31:0]        up, b4, b7, quot;
      r = '0;
      r.result_kind = item.operation;
      if (item.operation == 1'b0) begin
         ut = longint'(item.raw_reading[15:0]);
         x1 = (ut - longint'(shadow_ac56[15:0])) * longint'(shadow_ac56[31:16]);
         x1 = x1 >>> 15;   // floor, unlike every other division here
         den = x1 + longint'($signed(shadow_mcmd[15:0]));
         if (den == 0) begin
            r.divide_error = 1'b1;
         end else begin
            b5 = x1 + tdiv(longint'($signed(shadow_mcmd[31:16])) * 2048, den);
            shadow_b5 = b5[31:0];
            t = tdiv(b5 + 8, 16);
            if (t > 32767) t = 32767;
            if (t < -32768) t = -32768;
            r.temperature_tenths = t[15:0];
         end
      end else begin
         up = {8'd0, item.raw_reading} >> (8 - shadow_oss);
         b6 = longint'(shadow_b5) - 4000;
         sq = tdiv(b6 * b6, 4096);
         x1 = tdiv(longint'($signed(shadow_b12[15:0])) * sq, 2048);
         x2 = tdiv(longint'($signed(shadow_ac12[15:0])) * b6, 2048);
         x3 = x1 + x2;
         b3 = tdiv((longint'($signed(shadow_ac12[31:16])) * 4 + x3) * (64'sd1 << shadow_oss)
                   + 2, 4);
         x1 = tdiv(longint'($signed(shadow_ac34[31:16])) * b6, 8192);
         x2 = tdiv(longint'($signed(shadow_b12[31:16])) * sq, 65536);
         x3 = tdiv(x1 + x2 + 2, 4);
         b4 = (32'(shadow_ac34[15:0]) * 32'(x3 + 32768)) / 32'd32768;
         if (b4 == 32'd0) begin
            r.divide_error = 1'b1;
         end else begin
            b7 = (up - b3[31:0]) * (32'd50000 >> shadow_oss);
            if (b7 < 32'h8000_0000) quot = (b7 * 32'd2) / b4;
            else quot = (b7 / b4) * 32'd2;
            p = longint'($signed(quot));
            x1 = tdiv(p, 256) * tdiv(p, 256);
            x1 = tdiv(x1 * 3038, 65536);
            x2 = tdiv(-7357 * p, 65536);
            p = p + tdiv(x1 + x2 + 3791, 16);
            if (p < 0) p = 0;
            if (p > 1048575) p = 1048575;
            r.pressure_pa = p[19:0];
         end
      end
      return r;
   endfunction

   // Result side: random stalls, compare each transfer with the oldest expectation.
   initial begin
      baro_rsp_type want;
      int           stall;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result transfer %p", rsp_data);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.result_kind !== want.result_kind) begin
                  $error("result_kind exp %0d got %0d", want.result_kind,
                         rsp_data.result_kind);
                  error_count++;
               end
               if (rsp_data.temperature_tenths !== want.temperature_tenths) begin
                  $error("temperature_tenths exp %0d got %0d", want.temperature_tenths,
                         rsp_data.temperature_tenths);
                  error_count++;
               end
               if (rsp_data.pressure_pa !== want.pressure_pa) begin
                  $error("pressure_pa exp %0d got %0d", want.pressure_pa,
                         rsp_data.pressure_pa);
                  error_count++;
               end
               if (rsp_data.divide_error !== want.divide_error) begin
                  $error("divide_error exp %0d got %0d", want.divide_error,
                         rsp_data.divide_error);
                  error_count++;
               end
            end
         end
         // Drop ready for a burst now and then, otherwise hold it high.
         if (rsp_stall_enable && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 7);
            rsp_ready <= 1'b0;
            repeat (stall - 1) @(posedge clock);
            @(posedge clock);
            // A transfer cannot happen while ready was low, so just raise it.
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Send one reading; the expectation is computed when the transfer happens.
   task automatic send_reading(input logic op, input logic [23:0] raw);
      int gap;
      if (req_gap_enable && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         repeat (gap) @(posedge clock);
      end
      req_data <= {op, raw};
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      expected_results.push_back(compensate(req_data));
      req_valid <= 1'b0;
      // The block stays busy after taking a request, so this edge costs nothing.
      @(posedge clock);
   endtask

   // Wait until every expected result has arrived.
   task automatic drain_results();
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // APB write: setup cycle, then access cycle.
   task automatic write_register(input logic [2:0] index, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      case (index)
         REG_AC1_AC2: shadow_ac12 = value;
         REG_AC3_AC4: shadow_ac34 = value;
         REG_AC5_AC6: shadow_ac56 = value;
         REG_B1_B2:   shadow_b12 = value;
         REG_MC_MD:   shadow_mcmd = value;
         REG_OSS:     shadow_oss = value[1:0];
         default: ;
      endcase
   endtask

   // Load the calibration set of a typical sensor, with the given oversampling.
   task automatic load_typical_calibration(input logic [1:0] oss);
      write_register(REG_AC1_AC2, {16'sd408, -16'sd72});
      write_register(REG_AC3_AC4, {-16'sd14383, 16'd32741});
      write_register(REG_AC5_AC6, {16'd32757, 16'd23153});
      write_register(REG_B1_B2, {16'sd6190, 16'sd4});
      write_register(REG_MC_MD, {-16'sd8711, 16'sd2868});
      write_register(REG_OSS, {30'd0, oss});
   endtask

   // Realistic calibration words with random jitter.
   task automatic load_jittered_calibration();
      write_register(REG_AC1_AC2, {16'(408 + $urandom_range(0, 200) - 100),
                                   16'(-72 + $urandom_range(0, 40) - 20)});
      write_register(REG_AC3_AC4, {16'(-14383 + $urandom_range(0, 2000) - 1000),
                                   16'(32741 + $urandom_range(0, 2000) - 1000)});
      write_register(REG_AC5_AC6, {16'(32757 - $urandom_range(0, 2000)),
                                   16'(23153 + $urandom_range(0, 2000) - 1000)});
      write_register(REG_B1_B2, {16'(6190 + $urandom_range(0, 400) - 200),
                                 16'(4 + $urandom_range(0, 8))});
      write_register(REG_MC_MD, {16'(-8711 + $urandom_range(0, 400) - 200),
                                 16'(2868 + $urandom_range(0, 400) - 200)});
      write_register(REG_OSS, 32'($urandom_range(0, 3)));
   endtask

   // Directed: reset values (every divisor zero), the typical sensor, field extremes.
   task automatic test_directed();
      send_reading(1'b0, 24'h00_6CFA);    // zero calibration: temperature divisor zero
      send_reading(1'b1, 24'hFF_FFFF);    // zero AC4: pressure divisor zero
      drain_results();
      load_typical_calibration(2'd0);
      send_reading(1'b0, 24'h00_6CFA);
      send_reading(1'b1, 24'h5D_23C0);
      send_reading(1'b0, 24'hFF_0000);    // upper temperature bits ignored
      send_reading(1'b0, 24'h00_FFFF);
      send_reading(1'b1, 24'h00_0000);
      send_reading(1'b1, 24'hFF_FFFF);
      drain_results();
      write_register(REG_OSS, 32'd3);
      send_reading(1'b1, 24'h5D_23C0);
      send_reading(1'b1, 24'hAA_AA55);
      drain_results();
      // Force saturation of the temperature with extreme MC and tiny MD.
      write_register(REG_MC_MD, {16'h7FFF, 16'h0001});
      write_register(REG_AC5_AC6, {16'd0, 16'd0});
      send_reading(1'b0, 24'h00_0000);
      send_reading(1'b1, 24'h00_1234);
      drain_results();
      write_register(REG_MC_MD, {16'h8000, 16'h0001});
      send_reading(1'b0, 24'h00_0000);
      drain_results();
      // Temperature divisor zero with nonzero calibration: X1 + MD is 0, B5 kept.
      write_register(REG_AC5_AC6, {16'hFFFF, 16'h0000});
      write_register(REG_MC_MD, {16'h1234, 16'h0000});
      send_reading(1'b0, 24'h00_0000);
      send_reading(1'b1, 24'h33_3333);
      drain_results();
   endtask

   // Random: realistic calibration with noise readings, plus fully random words.
   task automatic test_random(input int count, input bit calm);
      int i;
      for (i = 0; i < count; i++) begin
         if (i % 40 == 0) begin
            drain_results();
            if ($urandom_range(0, 4) == 0) begin
               write_register(REG_AC1_AC2, $urandom());
               write_register(REG_AC3_AC4, $urandom());
               write_register(REG_AC5_AC6, $urandom());
               write_register(REG_B1_B2, $urandom());
               write_register(REG_MC_MD, $urandom());
               write_register(REG_OSS, 32'($urandom_range(0, 3)));
            end else begin
               load_jittered_calibration();
            end
         end
         if (calm) begin
            req_gap_enable = 1'b0;
            rsp_stall_enable = 1'b0;
         end
         if ($urandom_range(0, 2) == 0)
            send_reading(1'b0, 24'($urandom_range(20000, 40000)) | (24'($urandom()) & 24'hFF_0000));
         else if ($urandom_range(0, 3) == 0)
            send_reading(1'($urandom()), 24'($urandom()));
         else
            send_reading(1'b1, 24'($urandom_range(20'h40000, 24'hFF_FFFF)));
      end
   endtask

   initial begin
      shadow_ac12 = '0; shadow_ac34 = '0; shadow_ac56 = '0;
      shadow_b12 = '0; shadow_mcmd = '0;
      shadow_oss = OSS_RESET;
      shadow_b5 = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(560, 1'b0);
      test_random(80, 1'b1);
      drain_results();
      repeat (150) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Slowest run: ~655 items, each at its slowest with the longest stall and gap, plus setup, times several.
   initial begin
      #(12 * 600000);
      $display("status: fail");
      $finish;
   end

endmodule
